// ----- rtl/core/sfr_pkg.sv -----
// Package for the serial frame receiver with XOR check.
// Holds frame constants and the controller state type; no dependencies.
`default_nettype none

package sfr_pkg;

    // Frame delimiters
    localparam logic [7:0] START_KIND0 = 8'hEC;
    localparam logic [7:0] START_KIND1 = 8'hDC;
    localparam logic [7:0] END_BYTE    = 8'hAA;

    // Body geometry: positions 1..BODY_LEN, a data byte at DROP_POS kills the frame
    localparam int unsigned BODY_LEN = 13;
    localparam int unsigned POS_W    = 4;
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(BODY_LEN);
    localparam logic [POS_W-1:0] DROP_POS  = POS_W'(BODY_LEN + 1);
    localparam logic [POS_W-1:0] LAST_IDX  = POS_W'(BODY_LEN - 1);

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,     // taking serial bytes
        S_SUM,      // reading the store to form the check
        S_EMIT_RD,  // issuing a read for the next result
        S_EMIT_LD   // loading the output register
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/core/serial_frame_receiver_xor_check_unit.sv -----
// Serial frame receiver with XOR check: top level.
// Frame store in a 13-entry synchronous memory; uses sfr_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall / i_rx_byte) takes one serial byte per
//   transaction. A start byte 0xEC or 0xDC opens a frame; following bytes are
//   stored at positions 1..13; 0xAA is stored when within them and closes
//   the frame. A data byte arriving at position 14 drops the frame silently.
//   Output channel (o_valid / i_stall / payload) carries the 13 stored bytes
//   of a closed frame, in position order, each with the frame kind and the
//   XOR check flag; o_last_of_frame marks position 13.
// Timing:
//   Ordinary bytes are taken with o_stall low. After the end byte
//   the store is read twice through its single read port: 13 reads with
//   registered data to form the check, then a read and a load per result,
//   so each frame end holds off input for that pass plus any output stall.
//   The input is held off (o_stall high) until the last result is loaded;
//   that result may still wait in the output register while new bytes flow.
// Reset:
//   Synchronous, active low. Hunting for a start byte, store reads as zeros
//   (per-entry valid bits), output register empty. No clearing pass.
// Output stall: the output register holds its transaction and the emit
//   sequence waits.
`default_nettype none

module serial_frame_receiver_xor_check_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // serial byte input
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [7:0]                i_rx_byte,
    // frame result output
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic                           o_frame_kind,
    output logic [sfr_pkg::POS_W-1:0]      o_byte_position,
    output logic [7:0]                     o_body_byte,
    output logic                           o_check_ok,
    output logic                           o_last_of_frame
);

    import sfr_pkg::*;

    // Frame store and its valid bits
    logic [7:0]          r_mem [BODY_LEN];
    logic [BODY_LEN-1:0] r_vld;

    // Control and datapath registers
    t_state              r_state, n_state;
    logic                r_in_frame, n_in_frame;
    logic [POS_W-1:0]    r_wpos, n_wpos;
    logic                r_kind, n_kind;
    logic [POS_W-1:0]    r_idx, n_idx;
    logic [7:0]          r_acc, n_acc;
    logic                r_ok, n_ok;
    logic                r_rd_pend, n_rd_pend;
    logic [POS_W-1:0]    r_rd_idx;
    logic [7:0]          r_rd_data;
    logic                r_rd_hit;
    logic                r_out_valid, n_out_valid;

    // Comb controls
    logic                in_acc;
    logic                out_free;
    logic                mem_we;
    logic [POS_W-1:0]    mem_waddr;
    logic                rd_en;
    logic                out_load;
    logic [7:0]          rd_word;
    logic [POS_W-1:0]    wpos_inc;

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign rd_word  = r_rd_hit ? r_rd_data : 8'h00;
    assign wpos_inc = r_wpos + POS_W'(1);
    assign mem_waddr = r_wpos - POS_W'(1);

    // Next state and controls
    always_comb begin
        n_state     = r_state;
        n_in_frame  = r_in_frame;
        n_wpos      = r_wpos;
        n_kind      = r_kind;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_ok        = r_ok;
        n_rd_pend   = 1'b0;
        n_out_valid = r_out_valid && i_stall;
        mem_we      = 1'b0;
        rd_en       = 1'b0;
        out_load    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!r_in_frame) begin
                        // hunting: only start bytes matter
                        if (i_rx_byte == START_KIND0 || i_rx_byte == START_KIND1) begin
                            n_kind     = (i_rx_byte == START_KIND1);
                            n_wpos     = POS_W'(1);
                            n_in_frame = 1'b1;
                        end
                    end else begin
                        mem_we = (r_wpos <= LAST_POS);
                        if (i_rx_byte == END_BYTE) begin
                            // close frame, start check pass
                            n_wpos     = POS_W'(1);
                            n_in_frame = 1'b0;
                            n_idx      = '0;
                            n_acc      = 8'h00;
                            n_state    = S_SUM;
                        end else if (wpos_inc > DROP_POS || wpos_inc == '0) begin
                            // overlong frame dropped
                            n_wpos     = POS_W'(1);
                            n_in_frame = 1'b0;
                        end else begin
                            n_wpos = wpos_inc;
                        end
                    end
                end
            end

            S_SUM: begin
                // issue reads 0..12, fold returning data
                if (r_idx <= LAST_IDX) begin
                    rd_en     = 1'b1;
                    n_rd_pend = 1'b1;
                    n_idx     = r_idx + POS_W'(1);
                end
                if (r_rd_pend) begin
                    if (r_rd_idx == LAST_IDX) begin
                        n_ok    = (r_acc == rd_word);
                        n_idx   = '0;
                        n_state = S_EMIT_RD;
                    end else begin
                        n_acc = r_acc ^ rd_word;
                    end
                end
            end

            S_EMIT_RD: begin
                rd_en   = 1'b1;
                n_state = S_EMIT_LD;
            end

            S_EMIT_LD: begin
                // read data holds until the output register frees up
                if (out_free) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_idx   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + POS_W'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_wpos      <= POS_W'(1);
            r_kind      <= 1'b0;
            r_idx       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_frame  <= n_in_frame;
            r_wpos      <= n_wpos;
            r_kind      <= n_kind;
            r_idx       <= n_idx;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Check accumulator
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_ok  <= n_ok;
    end

    // Valid bits: reset reads the store as zeros
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (mem_we) begin
            r_vld[mem_waddr] <= 1'b1;
        end
    end

    // Store write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= i_rx_byte;
        end
    end

    // Store read port, registered data
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx];
            r_rd_hit  <= r_vld[r_idx];
            r_rd_idx  <= r_idx;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_frame_kind    <= r_kind;
            o_byte_position <= r_idx + POS_W'(1);
            o_body_byte     <= rd_word;
            o_check_ok      <= r_ok;
            o_last_of_frame <= (r_idx == LAST_IDX);
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- rtl/core/sfr_checker.sv -----
// Port-level checks for the serial frame receiver, bound to its top level.
// Uses sfr_pkg for frame geometry.
`default_nettype none

module sfr_checker (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_valid,
    input wire logic                   o_stall,
    input wire logic [7:0]             i_rx_byte,
    input wire logic                   o_valid,
    input wire logic                   i_stall,
    input wire logic                   o_frame_kind,
    input wire logic [sfr_pkg::POS_W-1:0] o_byte_position,
    input wire logic [7:0]             o_body_byte,
    input wire logic                   o_check_ok,
    input wire logic                   o_last_of_frame
);

    import sfr_pkg::*;

    // A stalled serial byte transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_rx_byte))
        else $error("stalled input byte changed");

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_body_byte)
            && $stable(o_byte_position) && $stable(o_check_ok)
            && $stable(o_frame_kind) && $stable(o_last_of_frame))
        else $error("stalled result changed");

    // Positions stay within the frame body
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_byte_position != '0) && (o_byte_position <= LAST_POS))
        else $error("result position out of range");

    // Last flag only on the final position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_of_frame == (o_byte_position == LAST_POS)))
        else $error("last flag on wrong position");

    // Input is held off while a frame is still being emitted
    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_of_frame |-> o_stall)
        else $error("input taken mid-frame emission");

endmodule

bind serial_frame_receiver_xor_check_unit sfr_checker u_sfr_checker (.*);

`default_nettype wire
